// ===== src/msl_pkg.sv =====
// ----------------------------------------------------------------------------
// msl_pkg
// Shared types, constants and register map of the motor slew limiter and
// pulse mapper.
// ----------------------------------------------------------------------------
package msl_pkg;

  // Speed format: signed fixed point, 1 << SPEED_FRAC_BITS equals 100 percent
  localparam int SPEED_FRAC_BITS = 14;
  localparam int SPEED_W         = 16;
  localparam int STEP_W          = 15;
  localparam int US_W            = 12;

  // Ramp arithmetic: speed plus or minus a step, with headroom
  localparam int RAMP_W = SPEED_W + 2;

  // Pulse mapping: span (us difference) times speed, then floor shift
  localparam int SPAN_W = US_W + 1;
  localparam int PROD_W = SPAN_W + SPEED_W;
  localparam int OFS_W  = PROD_W - SPEED_FRAC_BITS;
  localparam int SUM_W  = ((OFS_W > SPAN_W) ? OFS_W : SPAN_W) + 2;
  localparam logic [US_W-1:0] PULSE_MAX = {US_W{1'b1}};

  // Register map
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int ADDR_W    = REG_IDX_W + 2;
  localparam int DATA_W    = 32;

  localparam logic [REG_IDX_W-1:0] REG_MAX_SPEED   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RAMP_UP     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RAMP_DOWN   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RAMP_EN     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_NEUTRAL_US  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MIN_US      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MAX_US      = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_REVERSE_DIR = 3'd7;

  // Reset values
  localparam logic [STEP_W-1:0] RST_MAX_SPEED = 15'd16384;
  localparam logic [STEP_W-1:0] RST_RAMP_UP   = 15'd1638;
  localparam logic [STEP_W-1:0] RST_RAMP_DOWN = 15'd1638;
  localparam logic [US_W-1:0]   RST_NEUTRAL   = 12'd1500;
  localparam logic [US_W-1:0]   RST_MIN_US    = 12'd1000;
  localparam logic [US_W-1:0]   RST_MAX_US    = 12'd2000;

  // Command codes
  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_STOP = 1'b1;

  // Stream packing
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  // Command queue depth (power of two)
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = PTR_W + 1;

  typedef struct packed {
    logic [STEP_W-1:0] max_speed;
    logic [STEP_W-1:0] ramp_up;
    logic [STEP_W-1:0] ramp_down;
    logic              ramp_en;
    logic [US_W-1:0]   neutral_us;
    logic [US_W-1:0]   min_us;
    logic [US_W-1:0]   max_us;
    logic              reverse_dir;
  } msl_cfg_t;

  // Classified command as it sits in the queue
  typedef struct packed {
    logic               stop;
    logic [SPEED_W-1:0] want;
  } msl_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } msl_q_stat_t;

endpackage

// ===== src/msl_regs.sv =====
// ----------------------------------------------------------------------------
// msl_regs
// APB-style configuration registers with readback.
// ----------------------------------------------------------------------------
module msl_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msl_pkg::ADDR_W-1:0]    paddr,
  input  logic [msl_pkg::DATA_W-1:0]    pwdata,
  output logic [msl_pkg::DATA_W-1:0]    prdata,
  output msl_pkg::msl_cfg_t             cfg
);

  msl_pkg::msl_cfg_t cfg_r;
  logic [msl_pkg::REG_IDX_W-1:0] idx;
  logic wr_en;

  assign idx   = paddr[msl_pkg::ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_speed   <= msl_pkg::RST_MAX_SPEED;
      cfg_r.ramp_up     <= msl_pkg::RST_RAMP_UP;
      cfg_r.ramp_down   <= msl_pkg::RST_RAMP_DOWN;
      cfg_r.ramp_en     <= 1'b1;
      cfg_r.neutral_us  <= msl_pkg::RST_NEUTRAL;
      cfg_r.min_us      <= msl_pkg::RST_MIN_US;
      cfg_r.max_us      <= msl_pkg::RST_MAX_US;
      cfg_r.reverse_dir <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        msl_pkg::REG_MAX_SPEED:   cfg_r.max_speed   <= pwdata[msl_pkg::STEP_W-1:0];
        msl_pkg::REG_RAMP_UP:     cfg_r.ramp_up     <= pwdata[msl_pkg::STEP_W-1:0];
        msl_pkg::REG_RAMP_DOWN:   cfg_r.ramp_down   <= pwdata[msl_pkg::STEP_W-1:0];
        msl_pkg::REG_RAMP_EN:     cfg_r.ramp_en     <= pwdata[0];
        msl_pkg::REG_NEUTRAL_US:  cfg_r.neutral_us  <= pwdata[msl_pkg::US_W-1:0];
        msl_pkg::REG_MIN_US:      cfg_r.min_us      <= pwdata[msl_pkg::US_W-1:0];
        msl_pkg::REG_MAX_US:      cfg_r.max_us      <= pwdata[msl_pkg::US_W-1:0];
        msl_pkg::REG_REVERSE_DIR: cfg_r.reverse_dir <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      msl_pkg::REG_MAX_SPEED:
        prdata = msl_pkg::DATA_W'(cfg_r.max_speed);
      msl_pkg::REG_RAMP_UP:
        prdata = msl_pkg::DATA_W'(cfg_r.ramp_up);
      msl_pkg::REG_RAMP_DOWN:
        prdata = msl_pkg::DATA_W'(cfg_r.ramp_down);
      msl_pkg::REG_RAMP_EN:
        prdata = msl_pkg::DATA_W'(cfg_r.ramp_en);
      msl_pkg::REG_NEUTRAL_US:
        prdata = msl_pkg::DATA_W'(cfg_r.neutral_us);
      msl_pkg::REG_MIN_US:
        prdata = msl_pkg::DATA_W'(cfg_r.min_us);
      msl_pkg::REG_MAX_US:
        prdata = msl_pkg::DATA_W'(cfg_r.max_us);
      msl_pkg::REG_REVERSE_DIR:
        prdata = msl_pkg::DATA_W'(cfg_r.reverse_dir);
      default: prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== src/msl_front.sv =====
// ----------------------------------------------------------------------------
// msl_front
// Input side: takes commands, classifies set/stop and clamps the target.
// ----------------------------------------------------------------------------
module msl_front (
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic                              in_tuser,
  input  logic [msl_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [msl_pkg::STEP_W-1:0]        max_speed,
  input  msl_pkg::msl_q_stat_t              q_stat,
  output logic                              push,
  output msl_pkg::msl_item_t                item
);

  logic signed [msl_pkg::SPEED_W:0] want;
  logic signed [msl_pkg::SPEED_W:0] lim;
  logic signed [msl_pkg::SPEED_W:0] clamped;

  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && in_tready;

  assign want = (msl_pkg::SPEED_W+1)'($signed(in_tdata[msl_pkg::SPEED_W-1:0]));
  assign lim  = $signed({2'b00, max_speed});

  always_comb begin
    priority if (want < -lim) begin
      clamped = -lim;
    end else if (want > lim) begin
      clamped = lim;
    end else begin
      clamped = want;
    end
  end

  // stop commands carry no speed
  assign item.stop = (in_tuser == msl_pkg::CMD_STOP);
  assign item.want = item.stop ? '0 : clamped[msl_pkg::SPEED_W-1:0];

endmodule

// ===== src/msl_fifo.sv =====
// ----------------------------------------------------------------------------
// msl_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module msl_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  msl_pkg::msl_item_t   wr_item,
  input  logic                 pop,
  output msl_pkg::msl_item_t   rd_item,
  output msl_pkg::msl_q_stat_t stat
);

  msl_pkg::msl_item_t mem_r [msl_pkg::FIFO_DEPTH];
  logic [msl_pkg::PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [msl_pkg::PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [msl_pkg::CNT_W-1:0] count_r, count_nxt;

  assign wr_ptr_nxt = push ? wr_ptr_r + msl_pkg::PTR_W'(1) : wr_ptr_r;
  assign rd_ptr_nxt = pop  ? rd_ptr_r + msl_pkg::PTR_W'(1) : rd_ptr_r;
  assign count_nxt  = count_r + msl_pkg::CNT_W'(push) - msl_pkg::CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  assign rd_item    = mem_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == msl_pkg::CNT_W'(msl_pkg::FIFO_DEPTH));

endmodule

// ===== src/msl_back.sv =====
// ----------------------------------------------------------------------------
// msl_back
// Execution side: slew limiting of the kept speed, pulse mapping, output reg.
// ----------------------------------------------------------------------------
module msl_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  msl_pkg::msl_cfg_t                 cfg,
  input  msl_pkg::msl_q_stat_t              q_stat,
  input  msl_pkg::msl_item_t                q_item,
  output logic                              pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [msl_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int SW = msl_pkg::RAMP_W;

  logic advance;

  // stage 1: ramp, the kept speed is the stage register
  logic signed [msl_pkg::SPEED_W-1:0] applied_speed_r, applied_speed_nxt;
  logic s1_valid_r;
  logic signed [SW-1:0] cur, want, up, down, ramp;

  // stage 2: product
  logic signed [msl_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [msl_pkg::SPEED_W-1:0] s2_speed_r;
  logic signed [msl_pkg::SPAN_W-1:0]  span, span_d;
  logic s2_valid_r;

  // output stage
  logic signed [msl_pkg::OFS_W-1:0] ofs;
  logic signed [msl_pkg::SUM_W-1:0] sum;
  logic [msl_pkg::US_W-1:0]         pulse_nxt, pulse_r;
  logic [msl_pkg::SPEED_W-1:0]      out_speed_r;
  logic out_valid_r;

  assign advance = !out_valid_r || out_tready;
  assign pop     = !q_stat.empty && advance;

  assign cur  = SW'(applied_speed_r);
  assign want = SW'($signed(q_item.want));
  assign up   = $signed({3'b000, cfg.ramp_up});
  assign down = $signed({3'b000, cfg.ramp_down});

  always_comb begin
    priority if (!cfg.ramp_en) begin
      ramp = want;
    end else if (cur > 0) begin
      priority if (want > cur + up)        ramp = cur + up;
      else if (want < cur - down)          ramp = cur - down;
      else                                 ramp = want;
    end else if (cur < 0) begin
      priority if (want < cur - up)        ramp = cur - up;
      else if (want > cur + down)          ramp = cur + down;
      else                                 ramp = want;
    end else begin
      // standstill: up step in both directions
      priority if (up < want)              ramp = up;
      else if (up < -want)                 ramp = -up;
      else                                 ramp = want;
    end
  end

  assign applied_speed_nxt = q_item.stop ? '0 : ramp[msl_pkg::SPEED_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      applied_speed_r <= '0;
    end else if (pop) begin
      applied_speed_r <= applied_speed_nxt;
    end
  end

  // span toward min or max, sign of mounting direction folded in
  always_comb begin
    if (applied_speed_r < 0) begin
      span = $signed({1'b0, cfg.min_us}) - $signed({1'b0, cfg.neutral_us});
    end else begin
      span = $signed({1'b0, cfg.max_us}) - $signed({1'b0, cfg.neutral_us});
    end
    span_d = cfg.reverse_dir ? -span : span;
  end

  assign prod_nxt = msl_pkg::PROD_W'(span_d) * msl_pkg::PROD_W'(applied_speed_r);

  always_ff @(posedge clk) begin
    if (advance) begin
      prod_r     <= prod_nxt;
      s2_speed_r <= applied_speed_r;
    end
  end

  // arithmetic shift is the floor division
  assign ofs = msl_pkg::OFS_W'(prod_r >>> msl_pkg::SPEED_FRAC_BITS);

  always_comb begin
    if (s2_speed_r < 0) begin
      sum = $signed({{(msl_pkg::SUM_W-msl_pkg::US_W){1'b0}}, cfg.neutral_us})
            - msl_pkg::SUM_W'(ofs);
    end else begin
      sum = $signed({{(msl_pkg::SUM_W-msl_pkg::US_W){1'b0}}, cfg.neutral_us})
            + msl_pkg::SUM_W'(ofs);
    end
    priority if (sum < 0) begin
      pulse_nxt = '0;
    end else if (sum > $signed({{(msl_pkg::SUM_W-msl_pkg::US_W){1'b0}},
                                msl_pkg::PULSE_MAX})) begin
      pulse_nxt = msl_pkg::PULSE_MAX;
    end else begin
      pulse_nxt = sum[msl_pkg::US_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pulse_r     <= pulse_nxt;
      out_speed_r <= s2_speed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= pop;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(msl_pkg::OUT_TDATA_W-msl_pkg::US_W-msl_pkg::SPEED_W){1'b0}},
                       out_speed_r, pulse_r};

endmodule

// ===== src/motor_slew_limiter_pulse_mapper_top.sv =====
// ----------------------------------------------------------------------------
// motor_slew_limiter_pulse_mapper_top
// Slew-rate limiter for a speed command with servo pulse-width mapping.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake                  Payload
//  in_      in   in_tvalid/in_tready        tuser: cmd; tdata: target_speed
//  out_     out  out_tvalid/out_tready      tdata: pulse_us, current_speed
//  cfg_     in   psel/penable/pwrite/pready 8 registers at 4*i, 32-bit data
//
//  One command per cycle sustained while out_tready is not held low; out_tvalid
//  rises once a command has passed the queue write on its accepting edge,
//  then the ramp stage, the multiply stage and the output register.
//  The ramp stage updates the kept speed register on each pop, so back-to-back
//  commands see the previous result with no gap.
//  rst_n is synchronous; it empties the queue and pipeline, zeroes the kept
//  speed and loads the register defaults.
//  An output stall freezes the back pipeline; the two-entry queue keeps
//  taking commands until it fills, then in_tready drops.
// ----------------------------------------------------------------------------
module motor_slew_limiter_pulse_mapper_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // command stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic                            in_tuser,   // [0] cmd
  input  logic [msl_pkg::IN_TDATA_W-1:0]  in_tdata,   // [15:0] target_speed
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [msl_pkg::OUT_TDATA_W-1:0] out_tdata,  // [11:0] pulse_us,
                                                      // [27:12] current_speed
  // configuration
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [msl_pkg::ADDR_W-1:0]      cfg_paddr,
  input  logic [msl_pkg::DATA_W-1:0]      cfg_pwdata,
  output logic [msl_pkg::DATA_W-1:0]      cfg_prdata,
  output logic                            cfg_pready
);

  msl_pkg::msl_cfg_t    cfg;
  msl_pkg::msl_q_stat_t q_stat;
  msl_pkg::msl_item_t   wr_item;
  msl_pkg::msl_item_t   rd_item;
  logic                 push;
  logic                 pop;

  // register file never waits
  assign cfg_pready = 1'b1;

  msl_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // front: clamp target against max_speed, tag stop commands
  msl_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .max_speed (cfg.max_speed),
    .q_stat    (q_stat),
    .push      (push),
    .item      (wr_item)
  );

  msl_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .stat    (q_stat)
  );

  // back: ramp the kept speed, then map to a pulse width
  msl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_stat     (q_stat),
    .q_item     (rd_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
